/* rtl/itch_feed_stats_parser_core_macros.svh */
// assertion helpers shared by the parser modules
`ifndef ITCH_FEED_STATS_PARSER_CORE_MACROS_SVH
`define ITCH_FEED_STATS_PARSER_CORE_MACROS_SVH

// checked on every clock edge outside reset
`define IFSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define IFSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/ifsp_pkg.sv */
package ifsp_pkg;

  typedef enum logic [1:0] {
    PH_LEN_HI  = 2'd0,
    PH_LEN_LO  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALT    = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_DONE        = 3'd0,
    ST_CLEAN_END   = 3'd1,
    ST_CUT_PREFIX  = 3'd2,
    ST_CUT_PAYLOAD = 3'd3,
    ST_ZERO_LEN    = 3'd4,
    ST_SHORT_ADD   = 3'd5
  } status_e;

  localparam logic CFG_ADD_TYPE    = 1'b0;
  localparam logic CFG_ADD_MIN_LEN = 1'b1;

  localparam logic [7:0]  ADD_TYPE_RST    = 8'd65;
  localparam logic [15:0] ADD_MIN_LEN_RST = 16'd36;

  localparam logic [15:0] TS_FIRST   = 16'd5;
  localparam logic [15:0] TS_LAST    = 16'd10;
  localparam logic [15:0] SH_FIRST   = 16'd20;
  localparam logic [15:0] SH_LAST    = 16'd23;
  localparam logic [15:0] TS_MIN_LEN = 16'd11;

  typedef struct packed {
    status_e     status;
    logic        ts_upd;
    logic        is_add;
    logic [7:0]  mtype;
    logic [47:0] ts;
    logic [31:0] shares;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  message_type;
    logic [31:0] message_count;
    logic [31:0] add_count;
    logic [63:0] shares_total;
    logic [47:0] first_stamp;
    logic [47:0] last_stamp;
    logic [31:0] backward_count;
  } result_t;

endpackage

/* rtl/itch_feed_stats_parser_core.sv */
// channel   direction  handshake            payload
// input     in         push_i / full_o      mode_i, data_byte_i
// result    out        pop_i / empty_o      status_o .. backward_count_o
// config    in         cfg_we_i             cfg_addr_i, cfg_wdata_i
//
// one feed byte per cycle while full_o is low; the front parser updates
// framing state in the transfer cycle and queues a command, the back end
// pops it and applies it to the statistics once the result queue has room
// full_o rises only when the command queue is full; bytes that give no result
// still wait then. reset (rst_ni low, async) returns to the first length byte
module itch_feed_stats_parser_core #(
  parameter int COUNT_WIDTH = 32,
  parameter int CMD_DEPTH   = 2,
  parameter int RES_DEPTH   = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        push_i,
  output logic        full_o,
  input  logic        mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [2:0]  status_o,
  output logic [7:0]  message_type_o,
  output logic [31:0] message_count_o,
  output logic [31:0] add_count_o,
  output logic [63:0] shares_total_o,
  output logic [47:0] first_stamp_o,
  output logic [47:0] last_stamp_o,
  output logic [31:0] backward_count_o
);
  import ifsp_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(result_t);

  logic             accept;
  logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t             cmd_in, cmd_head;
  logic [CMD_W-1:0] cmd_rdata;
  logic             res_push, res_full;
  result_t          res_in, res_head;
  logic [RES_W-1:0] res_rdata;

  assign accept = push_i && !full_o;
  assign full_o = cmd_full;

  ifsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .mode_i      (mode_i),
    .data_byte_i (data_byte_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  ifsp_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_rdata),
    .empty_o (cmd_empty)
  );

  assign cmd_head = cmd_t'(cmd_rdata);

  ifsp_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  ifsp_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .data_o  (res_rdata),
    .empty_o (empty_o)
  );

  assign res_head         = result_t'(res_rdata);
  assign status_o         = res_head.status;
  assign message_type_o   = res_head.message_type;
  assign message_count_o  = res_head.message_count;
  assign add_count_o      = res_head.add_count;
  assign shares_total_o   = res_head.shares_total;
  assign first_stamp_o    = res_head.first_stamp;
  assign last_stamp_o     = res_head.last_stamp;
  assign backward_count_o = res_head.backward_count;

endmodule

/* rtl/ifsp_fifo.sv */
`include "itch_feed_stats_parser_core_macros.svh"

module ifsp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `IFSP_ASSERT(a_no_push_full, push_i |-> !full_o, "push into full queue")
  `IFSP_ASSERT(a_full_holds, full_o && !do_pop |=> full_o, "full queue lost an entry")
  `IFSP_ASSERT(a_cnt_range, cnt_q <= CW'(DEPTH), "queue count out of range")

endmodule

/* rtl/ifsp_front.sv */
`include "itch_feed_stats_parser_core_macros.svh"

module ifsp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_addr_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          accept_i,
  input  logic          mode_i,
  input  logic [7:0]    data_byte_i,
  output logic          cmd_push_o,
  output ifsp_pkg::cmd_t cmd_o
);
  import ifsp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  type_q, type_d;
  logic [47:0] ts_q, ts_d;
  logic [31:0] sh_q, sh_d;
  logic [7:0]  add_type_q;
  logic [15:0] add_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      add_type_q <= ADD_TYPE_RST;
      add_min_q  <= ADD_MIN_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_ADD_TYPE:    add_type_q <= cfg_wdata_i[7:0];
        CFG_ADD_MIN_LEN: add_min_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    pos_d      = pos_q;
    type_d     = type_q;
    ts_d       = ts_q;
    sh_d       = sh_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    if (accept_i && phase_q != PH_HALT) begin
      if (mode_i) begin
        cmd_push_o = 1'b1;
        phase_d    = PH_HALT;
        priority if (phase_q == PH_LEN_HI) begin
          cmd_o.status = ST_CLEAN_END;
        end else if (phase_q == PH_LEN_LO) begin
          cmd_o.status = ST_CUT_PREFIX;
        end else begin
          cmd_o.status = ST_CUT_PAYLOAD;
        end
      end else begin
        unique case (phase_q)
          PH_LEN_HI: begin
            len_d   = {data_byte_i, 8'h00};
            phase_d = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len_d = {len_q[15:8], data_byte_i};
            if (len_d == '0) begin
              cmd_push_o   = 1'b1;
              cmd_o.status = ST_ZERO_LEN;
              phase_d      = PH_HALT;
            end else begin
              pos_d   = '0;
              type_d  = '0;
              ts_d    = '0;
              sh_d    = '0;
              phase_d = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            if (pos_q == '0) begin
              type_d = data_byte_i;
            end
            if (pos_q >= TS_FIRST && pos_q <= TS_LAST) begin
              ts_d = {ts_q[39:0], data_byte_i};
            end
            if (pos_q >= SH_FIRST && pos_q <= SH_LAST) begin
              sh_d = {sh_q[23:0], data_byte_i};
            end
            if (({1'b0, pos_q} + 17'd1) < {1'b0, len_q}) begin
              pos_d = pos_q + 16'd1;
            end else begin
              // last payload byte: hand the message to the back end
              cmd_push_o   = 1'b1;
              cmd_o.ts     = ts_d;
              cmd_o.shares = sh_d;
              cmd_o.ts_upd = (len_q >= TS_MIN_LEN);
              cmd_o.is_add = (type_d == add_type_q);
              if (cmd_o.is_add && len_q < add_min_q) begin
                cmd_o.status = ST_SHORT_ADD;
                phase_d      = PH_HALT;
              end else begin
                cmd_o.status = ST_DONE;
                cmd_o.mtype  = type_d;
                phase_d      = PH_LEN_HI;
                pos_d        = '0;
              end
            end
          end
          PH_HALT: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEN_HI;
      len_q   <= '0;
      pos_q   <= '0;
      type_q  <= '0;
      ts_q    <= '0;
      sh_q    <= '0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      type_q  <= type_d;
      ts_q    <= ts_d;
      sh_q    <= sh_d;
    end
  end

  `IFSP_ASSERT(a_halt_sticky, phase_q == PH_HALT |=> phase_q == PH_HALT, "left halt state")
  `IFSP_ASSERT(a_push_on_accept, cmd_push_o |-> accept_i, "command without accepted byte")
  `IFSP_ASSERT(a_end_pushes, accept_i && mode_i && phase_q != PH_HALT |-> cmd_push_o,
               "end marker gave no command")

endmodule

/* rtl/ifsp_back.sv */
`include "itch_feed_stats_parser_core_macros.svh"

module ifsp_back #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ifsp_pkg::cmd_t    cmd_i,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output ifsp_pkg::result_t res_o
);
  import ifsp_pkg::*;

  logic [COUNT_WIDTH-1:0] msg_cnt_q, msg_cnt_d;
  logic [COUNT_WIDTH-1:0] add_cnt_q, add_cnt_d;
  logic [COUNT_WIDTH-1:0] bwd_cnt_q, bwd_cnt_d;
  logic [63:0]            shares_q, shares_d;
  logic [64:0]            shares_sum;
  logic [47:0]            first_q, first_d;
  logic [47:0]            last_q, last_d;
  logic                   have_ts_q, have_ts_d;

  function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + COUNT_WIDTH'(1);
  endfunction

  function automatic logic [31:0] clip32(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] wide;
    wide = 64'(c);
    return (wide[63:32] != '0) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  assign cmd_pop_o  = !cmd_empty_i && !res_full_i;
  assign res_push_o = cmd_pop_o;
  assign shares_sum = {1'b0, shares_q} + 65'(cmd_i.shares);

  always_comb begin
    msg_cnt_d = msg_cnt_q;
    add_cnt_d = add_cnt_q;
    bwd_cnt_d = bwd_cnt_q;
    shares_d  = shares_q;
    first_d   = first_q;
    last_d    = last_q;
    have_ts_d = have_ts_q;
    if (cmd_pop_o) begin
      if (cmd_i.ts_upd) begin
        if (!have_ts_q) begin
          first_d   = cmd_i.ts;
          have_ts_d = 1'b1;
        end else if (cmd_i.ts < last_q) begin
          bwd_cnt_d = bump(bwd_cnt_q);
        end
        last_d = cmd_i.ts;
      end
      if (cmd_i.status == ST_DONE) begin
        msg_cnt_d = bump(msg_cnt_q);
        if (cmd_i.is_add) begin
          add_cnt_d = bump(add_cnt_q);
          shares_d  = shares_sum[64] ? '1 : shares_sum[63:0];
        end
      end
    end
    res_o.status         = cmd_i.status;
    res_o.message_type   = cmd_i.mtype;
    res_o.message_count  = clip32(msg_cnt_d);
    res_o.add_count      = clip32(add_cnt_d);
    res_o.shares_total   = shares_d;
    res_o.first_stamp    = first_d;
    res_o.last_stamp     = last_d;
    res_o.backward_count = clip32(bwd_cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_cnt_q <= '0;
      add_cnt_q <= '0;
      bwd_cnt_q <= '0;
      shares_q  <= '0;
      first_q   <= '0;
      last_q    <= '0;
      have_ts_q <= 1'b0;
    end else begin
      msg_cnt_q <= msg_cnt_d;
      add_cnt_q <= add_cnt_d;
      bwd_cnt_q <= bwd_cnt_d;
      shares_q  <= shares_d;
      first_q   <= first_d;
      last_q    <= last_d;
      have_ts_q <= have_ts_d;
    end
  end

  `IFSP_ASSERT(a_idle_stable, !cmd_pop_o |=> $stable(msg_cnt_q) && $stable(shares_q),
               "statistics moved without a command")
  `IFSP_ASSERT(a_adds_le_msgs, add_cnt_q <= msg_cnt_q, "more adds than messages")
  `IFSP_ASSERT(a_no_ts_zero, !have_ts_q |-> last_q == '0 && first_q == '0,
               "timestamp set without a sample")

endmodule

/* tb/tb.sv */
module tb;
  import ifsp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  class feed_stats_tracker;
    logic [7:0]  add_code;
    logic [15:0] add_min;
    phase_e      ph;
    logic [15:0] msg_len;
    logic [15:0] pos;
    logic [7:0]  pend_type;
    logic [47:0] ts_acc;
    logic [31:0] shares_acc;
    logic [31:0] n_msgs;
    logic [31:0] n_adds;
    logic [31:0] n_back;
    logic [63:0] shares_sum;
    logic [47:0] ts_first;
    logic [47:0] ts_last;
    bit          ts_seen;
    result_t     due[$];
    int          produced;
    int          errors;

    function new();
      add_code   = ADD_TYPE_RST;
      add_min    = ADD_MIN_LEN_RST;
      ph         = PH_LEN_HI;
      msg_len    = '0;
      pos        = '0;
      pend_type  = '0;
      ts_acc     = '0;
      shares_acc = '0;
      n_msgs     = '0;
      n_adds     = '0;
      n_back     = '0;
      shares_sum = '0;
      ts_first   = '0;
      ts_last    = '0;
      ts_seen    = 1'b0;
      produced   = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic addr, logic [15:0] data);
      if (addr == CFG_ADD_TYPE) begin
        add_code = data[7:0];
      end else begin
        add_min = data;
      end
    endfunction

    function logic [31:0] sat_inc(logic [31:0] v);
      return (v == '1) ? v : v + 32'd1;
    endfunction

    function void emit(status_e st, logic [7:0] mtype);
      result_t r;
      r.status         = st;
      r.message_type   = mtype;
      r.message_count  = n_msgs;
      r.add_count      = n_adds;
      r.shares_total   = shares_sum;
      r.first_stamp    = ts_first;
      r.last_stamp     = ts_last;
      r.backward_count = n_back;
      due.push_back(r);
      produced++;
    endfunction

    // message commit on the last payload byte
    function void commit();
      if (msg_len >= TS_MIN_LEN) begin
        if (!ts_seen) begin
          ts_first = ts_acc;
          ts_seen  = 1'b1;
        end else if (ts_acc < ts_last) begin
          n_back = sat_inc(n_back);
        end
        ts_last = ts_acc;
      end
      if (pend_type == add_code) begin
        if (msg_len < add_min) begin
          ph = PH_HALT;
          emit(ST_SHORT_ADD, 8'h00);
          return;
        end
        n_adds = sat_inc(n_adds);
        if (shares_sum > ~64'd0 - 64'(shares_acc)) begin
          shares_sum = '1;
        end else begin
          shares_sum = shares_sum + 64'(shares_acc);
        end
      end
      n_msgs = sat_inc(n_msgs);
      ph     = PH_LEN_HI;
      pos    = '0;
      emit(ST_DONE, pend_type);
    endfunction

    function void take_byte(logic m, logic [7:0] b);
      if (ph == PH_HALT) return;
      if (m) begin
        case (ph)
          PH_LEN_HI: emit(ST_CLEAN_END, 8'h00);
          PH_LEN_LO: emit(ST_CUT_PREFIX, 8'h00);
          default:   emit(ST_CUT_PAYLOAD, 8'h00);
        endcase
        ph = PH_HALT;
        return;
      end
      case (ph)
        PH_LEN_HI: begin
          msg_len = {b, 8'h00};
          ph      = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          msg_len[7:0] = b;
          if (msg_len == '0) begin
            ph = PH_HALT;
            emit(ST_ZERO_LEN, 8'h00);
          end else begin
            pos        = '0;
            pend_type  = '0;
            ts_acc     = '0;
            shares_acc = '0;
            ph         = PH_PAYLOAD;
          end
        end
        default: begin
          if (pos == '0) pend_type = b;
          if (pos >= TS_FIRST && pos <= TS_LAST) ts_acc = {ts_acc[39:0], b};
          if (pos >= SH_FIRST && pos <= SH_LAST) shares_acc = {shares_acc[23:0], b};
          if (17'(pos) + 17'd1 < 17'(msg_len)) begin
            pos = pos + 16'd1;
          end else begin
            commit();
          end
        end
      endcase
    endfunction

    function void check_field(string name, logic [63:0] e, logic [63:0] a);
      if (a !== e) begin
        errors++;
        $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      end
    endfunction

    function void match_result(result_t act);
      result_t exp;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result with none due, expected nothing actual status %0d",
                 $time, act.status);
        return;
      end
      exp = due.pop_front();
      check_field("status", exp.status, act.status);
      check_field("message_type", exp.message_type, act.message_type);
      check_field("message_count", exp.message_count, act.message_count);
      check_field("add_count", exp.add_count, act.add_count);
      check_field("shares_total", exp.shares_total, act.shares_total);
      check_field("first_stamp", exp.first_stamp, act.first_stamp);
      check_field("last_stamp", exp.last_stamp, act.last_stamp);
      check_field("backward_count", exp.backward_count, act.backward_count);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic [15:0] cfg_wdata_i;
  logic        push_i;
  logic        full_o;
  logic        mode_i;
  logic [7:0]  data_byte_i;
  logic        empty_o;
  logic        pop_i;
  logic [2:0]  status_o;
  logic [7:0]  message_type_o;
  logic [31:0] message_count_o;
  logic [31:0] add_count_o;
  logic [63:0] shares_total_o;
  logic [47:0] first_stamp_o;
  logic [47:0] last_stamp_o;
  logic [31:0] backward_count_o;

  feed_stats_tracker trk = new();
  result_t     seen_res;
  int          quiet;
  int          fed_bytes;
  int          tx_calm;
  int          rx_calm;
  bit          hold_req;
  logic [7:0]  cur_code;
  logic [15:0] cur_min;
  logic [47:0] clock_ns;

  itch_feed_stats_parser_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .push_i           (push_i),
    .full_o           (full_o),
    .mode_i           (mode_i),
    .data_byte_i      (data_byte_i),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .status_o         (status_o),
    .message_type_o   (message_type_o),
    .message_count_o  (message_count_o),
    .add_count_o      (add_count_o),
    .shares_total_o   (shares_total_o),
    .first_stamp_o    (first_stamp_o),
    .last_stamp_o     (last_stamp_o),
    .backward_count_o (backward_count_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) trk.write_reg(cfg_addr_i, cfg_wdata_i);
      if (push_i && !full_o) trk.take_byte(mode_i, data_byte_i);
      if (pop_i && !empty_o) begin
        seen_res.status         = status_e'(status_o);
        seen_res.message_type   = message_type_o;
        seen_res.message_count  = message_count_o;
        seen_res.add_count      = add_count_o;
        seen_res.shares_total   = shares_total_o;
        seen_res.first_stamp    = first_stamp_o;
        seen_res.last_stamp     = last_stamp_o;
        seen_res.backward_count = backward_count_o;
        trk.match_result(seen_res);
      end
      if (cfg_we_i || (push_i && !full_o) || (pop_i && !empty_o)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  task automatic feed_byte(input logic m, input logic [7:0] b);
    int g;
    g = pick_gap(tx_calm);
    if (g > 0) begin
      push_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push_i      <= 1'b1;
    mode_i      <= m;
    data_byte_i <= b;
    @(posedge clk_i);
    while (full_o) @(posedge clk_i);
    fed_bytes++;
  endtask

  task automatic feed_message(input logic [15:0] len, input logic [7:0] mtype,
                              input logic [47:0] ts, input logic [31:0] sh);
    int i;
    logic [7:0] b;
    feed_byte(1'b0, len[15:8]);
    feed_byte(1'b0, len[7:0]);
    for (i = 0; i < int'(len); i++) begin
      b = 8'($urandom);
      if (i == 0) begin
        b = mtype;
      end else if (i >= int'(TS_FIRST) && i <= int'(TS_LAST)) begin
        b = ts[8 * (int'(TS_LAST) - i) +: 8];
      end else if (i >= int'(SH_FIRST) && i <= int'(SH_LAST)) begin
        b = sh[8 * (int'(SH_LAST) - i) +: 8];
      end
      feed_byte(1'b0, b);
    end
  endtask

  function automatic logic [47:0] next_stamp();
    if ($urandom_range(0, 4) == 0) return {16'($urandom), 32'($urandom)};
    clock_ns = clock_ns + 48'($urandom_range(1, 5000));
    return clock_ns;
  endfunction

  function automatic logic [31:0] pick_shares();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return 32'($urandom);
  endfunction

  task automatic feed_random_message();
    int r;
    logic [15:0] len;
    logic [7:0]  mtype;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      len = 16'($urandom_range(1, 30));
    end else if (r < 95) begin
      len = 16'($urandom_range(31, 80));
    end else begin
      len = 16'($urandom_range(256, 400));
    end
    mtype = ($urandom_range(0, 99) < 45) ? cur_code : 8'($urandom);
    if (mtype == cur_code && len < cur_min) begin
      if (cur_min <= 16'd80) begin
        len = cur_min;
      end else begin
        mtype = cur_code + 8'd1;
      end
    end
    feed_message(len, mtype, next_stamp(), pick_shares());
  endtask

  task automatic run_traffic(input int n_bytes, input int n_results);
    int b0;
    int p0;
    b0 = fed_bytes;
    p0 = trk.produced;
    while (fed_bytes - b0 < n_bytes || trk.produced - p0 < n_results) begin
      feed_random_message();
    end
  endtask

  // idle the sender until every due result is back and the pipe has settled
  task automatic drain_feed();
    push_i <= 1'b0;
    while (trk.due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic addr, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [7:0] code, input logic [15:0] min_len);
    write_reg(CFG_ADD_TYPE, {8'h00, code});
    write_reg(CFG_ADD_MIN_LEN, min_len);
    cfg_we_i <= 1'b0;
    cur_code = code;
    cur_min  = min_len;
  endtask

  task automatic end_stream();
    status_e     pick;
    logic [15:0] len;
    int          cut;
    int          i;
    pick = status_e'($urandom_range(int'(ST_CLEAN_END), int'(ST_SHORT_ADD)));
    case (pick)
      ST_CLEAN_END: begin
        feed_byte(1'b1, 8'($urandom));
      end
      ST_CUT_PREFIX: begin
        feed_byte(1'b0, 8'($urandom));
        feed_byte(1'b1, 8'($urandom));
      end
      ST_CUT_PAYLOAD: begin
        len = 16'($urandom_range(1, 30));
        cut = $urandom_range(0, int'(len) - 1);
        feed_byte(1'b0, len[15:8]);
        feed_byte(1'b0, len[7:0]);
        for (i = 0; i < cut; i++) feed_byte(1'b0, 8'($urandom));
        feed_byte(1'b1, 8'($urandom));
      end
      ST_ZERO_LEN: begin
        feed_byte(1'b0, 8'h00);
        feed_byte(1'b0, 8'h00);
      end
      default: begin
        len = 16'($urandom_range(1, int'(cur_min) - 1));
        feed_message(len, cur_code, next_stamp(), pick_shares());
      end
    endcase
  endtask

  // result side with random stalls and one long hold-off
  initial begin
    int g;
    pop_i = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      g = pick_gap(rx_calm);
      if (hold_req) begin
        hold_req = 1'b0;
        pop_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (g > 0) begin
        pop_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      pop_i <= 1'b1;
      @(posedge clk_i);
      while (empty_o) @(posedge clk_i);
    end
  end

  initial begin
    int i;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = CFG_ADD_TYPE;
    cfg_wdata_i = '0;
    push_i      = 1'b0;
    mode_i      = 1'b0;
    data_byte_i = '0;
    quiet       = 0;
    fed_bytes   = 0;
    tx_calm     = 0;
    rx_calm     = 0;
    hold_req    = 1'b0;
    cur_code    = ADD_TYPE_RST;
    cur_min     = ADD_MIN_LEN_RST;
    clock_ns    = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // shortest message, all-ones then all-zero timestamp
    feed_message(16'd1, 8'h00, '0, '0);
    feed_message(16'd11, 8'hFF, '1, '0);
    feed_message(16'd11, 8'h12, '0, '0);

    drain_feed();
    set_config(8'h00, 16'd1);
    hold_req = 1'b1;
    run_traffic(100, 2);

    drain_feed();
    set_config(8'hFF, 16'hFFFF);
    run_traffic(100, 2);

    drain_feed();
    set_config(8'($urandom), 16'($urandom_range(20, 40)));
    run_traffic(100, 2);

    drain_feed();
    set_config(ADD_TYPE_RST, 16'd24);
    run_traffic(100, 2);

    drain_feed();
    end_stream();
    // halted: these must give nothing
    for (i = 0; i < 8; i++) feed_byte(1'($urandom), 8'($urandom));
    push_i <= 1'b0;

    while (trk.due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (trk.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/ifsp_pkg.sv
rtl/ifsp_fifo.sv
rtl/ifsp_front.sv
rtl/ifsp_back.sv
rtl/itch_feed_stats_parser_core.sv
tb/tb.sv
